[rtl/core/ufold_pkg.sv]
// Package for the UTF-8 to panel character folder.
// Holds the word types, byte constants, the Cyrillic ROM and the fold function.
// No dependencies.
`default_nettype none

package ufold_pkg;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       string_first;
      logic       string_last;
   } req_type;

   typedef struct packed {
      logic [7:0] panel_char;
      logic       char_valid;
      logic       string_end;
   } rsp_type;

   typedef struct packed {
      logic [1:0] num;
      rsp_type    slot0;
      rsp_type    slot1;
   } push_type;

   localparam logic [7:0] SELECTOR   = 8'h15;
   localparam logic [7:0] QMARK      = 8'h3F;
   localparam logic [7:0] ROM_BASE   = 8'hA0;
   localparam logic [7:0] CYR_OFF_D0 = 8'h20;
   localparam logic [7:0] CYR_OFF_D1 = 8'h60;
   localparam logic [7:0] LEAD_C3    = 8'hC3;
   localparam logic [7:0] LEAD_C4    = 8'hC4;
   localparam logic [7:0] LEAD_C5    = 8'hC5;
   localparam logic [7:0] LEAD_D0    = 8'hD0;
   localparam logic [7:0] LEAD_D1    = 8'hD1;
   localparam logic [7:0] LEAD_MIN   = 8'hC2;
   localparam logic [7:0] LEAD3_MIN  = 8'hE0;
   localparam logic [7:0] LEAD4_MIN  = 8'hF0;
   localparam logic [7:0] LEAD_MAX   = 8'hF7;
   localparam logic [7:0] RAW_LO     = 8'h8B;
   localparam logic [7:0] RAW_HI     = 8'h8E;
   localparam logic [7:0] RAW_ONE    = 8'h95;
   localparam logic [7:0] ASCII_MAX  = 8'h7F;

   localparam logic [7:0] CYR_ROM [96] = '{
      8'h20, 8'hA2, 8'h3F, 8'h3F, 8'h3F, 8'h53, 8'h49, 8'h49,
      8'h4A, 8'h3F, 8'h3F, 8'h3F, 8'h3F, 8'h3F, 8'hCC, 8'h3F,
      8'h41, 8'hA0, 8'h42, 8'hA1, 8'hE0, 8'h45, 8'hA3, 8'hA4,
      8'hA5, 8'hA6, 8'h4B, 8'hA7, 8'h4D, 8'h48, 8'h4F, 8'hA8,
      8'h50, 8'h43, 8'h54, 8'hA9, 8'hAA, 8'h58, 8'hE1, 8'hAB,
      8'hAC, 8'hE2, 8'hAD, 8'hAE, 8'h62, 8'hAF, 8'hB0, 8'hB1,
      8'h61, 8'hB2, 8'hB3, 8'hB4, 8'hE3, 8'h65, 8'hB6, 8'hB7,
      8'hB8, 8'hB9, 8'hBA, 8'hBB, 8'hBC, 8'hBD, 8'h6F, 8'hBE,
      8'h70, 8'h63, 8'hBF, 8'h79, 8'hE4, 8'h78, 8'hE5, 8'hC0,
      8'hC1, 8'hE6, 8'hC2, 8'hC3, 8'hC4, 8'hC5, 8'hC6, 8'hC7,
      8'h4E, 8'hB5, 8'h3F, 8'h3F, 8'h3F, 8'h73, 8'h69, 8'h69,
      8'h6A, 8'h3F, 8'h3F, 8'h3F, 8'h3F, 8'h3F, 8'hCC, 8'h3F
   };

   function automatic logic in_rng(input logic [7:0] v, input logic [7:0] lo,
                                   input logic [7:0] hi);
      return (v >= lo) && (v <= hi);
   endfunction

   function automatic logic [7:0] by_parity(input logic [7:0] c, input logic par,
                                            input logic [7:0] up, input logic [7:0] lo);
      return (c[0] == par) ? up : lo;
   endfunction

   function automatic logic [7:0] fold_two(input logic [7:0] lead, input logic [7:0] c,
                                           input logic rus);
      logic [7:0] v;
      logic [7:0] r;
      r = QMARK;
      v = c + ((lead == LEAD_D0) ? CYR_OFF_D0 : CYR_OFF_D1);
      if (lead == LEAD_C3) begin
         priority if (in_rng(c, 8'h80, 8'h85)) r = "A";
         else if (in_rng(c, 8'h88, 8'h8B)) r = "E";
         else if (in_rng(c, 8'h8C, 8'h8F)) r = "I";
         else if (in_rng(c, 8'h92, 8'h96)) r = "O";
         else if (in_rng(c, 8'h99, 8'h9C)) r = "U";
         else if (in_rng(c, 8'hA0, 8'hA5)) r = "a";
         else if (in_rng(c, 8'hA8, 8'hAB)) r = "e";
         else if (in_rng(c, 8'hAC, 8'hAF)) r = "i";
         else if (in_rng(c, 8'hB2, 8'hB6)) r = "o";
         else if (in_rng(c, 8'hB9, 8'hBC)) r = "u";
         else r = QMARK;
      end else if (lead == LEAD_C4) begin
         priority if (in_rng(c, 8'h80, 8'h85)) r = by_parity(c, 1'b0, "A", "a");
         else if (in_rng(c, 8'h86, 8'h8D)) r = by_parity(c, 1'b0, "C", "c");
         else if (in_rng(c, 8'h8E, 8'h91)) r = by_parity(c, 1'b0, "D", "d");
         else if (in_rng(c, 8'h92, 8'h9B)) r = by_parity(c, 1'b0, "E", "e");
         else if (in_rng(c, 8'h9C, 8'hA3)) r = by_parity(c, 1'b0, "G", "g");
         else if (in_rng(c, 8'hA4, 8'hA7)) r = by_parity(c, 1'b0, "H", "h");
         else if (in_rng(c, 8'hA8, 8'hB3)) r = by_parity(c, 1'b0, "I", "i");
         else if (in_rng(c, 8'hB4, 8'hB5)) r = by_parity(c, 1'b0, "J", "j");
         else if (in_rng(c, 8'hB6, 8'hB7)) r = by_parity(c, 1'b0, "K", "k");
         else if (c == 8'hB8) r = "k";
         else if (in_rng(c, 8'hB9, 8'hBF)) r = by_parity(c, 1'b1, "L", "l");
         else r = QMARK;
      end else if (lead == LEAD_C5) begin
         priority if (in_rng(c, 8'h80, 8'h82)) r = by_parity(c, 1'b1, "L", "l");
         else if (in_rng(c, 8'h83, 8'h88)) r = by_parity(c, 1'b1, "N", "n");
         else if (c == 8'h89) r = "n";
         else if (in_rng(c, 8'h8A, 8'h8B)) r = by_parity(c, 1'b0, "N", "n");
         else if (in_rng(c, 8'h8C, 8'h93)) r = by_parity(c, 1'b0, "O", "o");
         else if (in_rng(c, 8'h94, 8'h99)) r = by_parity(c, 1'b0, "R", "r");
         else if (in_rng(c, 8'h9A, 8'hA1)) r = by_parity(c, 1'b0, "S", "s");
         else if (in_rng(c, 8'hA2, 8'hA7)) r = by_parity(c, 1'b0, "T", "t");
         else if (in_rng(c, 8'hA8, 8'hB3)) r = by_parity(c, 1'b0, "U", "u");
         else if (in_rng(c, 8'hB4, 8'hB5)) r = by_parity(c, 1'b0, "W", "w");
         else if (in_rng(c, 8'hB6, 8'hB8)) r = by_parity(c, 1'b0, "Y", "y");
         else if (in_rng(c, 8'hB9, 8'hBE)) r = by_parity(c, 1'b1, "Z", "z");
         else r = QMARK;
      end else if (rus && (lead == LEAD_D0 || lead == LEAD_D1)) begin
         if (v < ROM_BASE) r = v;
         else r = CYR_ROM[7'(v - ROM_BASE)];
      end
      return r;
   endfunction

endpackage

`default_nettype wire

[rtl/core/ufold_front.sv]
// Front end: accepts input words, tracks the open UTF-8 sequence and the mode
// register, and builds up to two result words per input. Uses ufold_pkg.
`default_nettype none

module ufold_front
   import ufold_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     csr_wr_en,
   input  wire logic     csr_wr_data,
   input  wire logic     req_accept,
   input  wire req_type  req_data,
   output push_type      push
);

   logic       rus_ff, rus_in;
   logic [7:0] lead_ff, lead_in;
   logic [1:0] pend_ff, pend_in;
   logic       sel_ff, sel_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         rus_ff  <= 1'b0;
         lead_ff <= '0;
         pend_ff <= '0;
         sel_ff  <= 1'b0;
      end else begin
         rus_ff  <= rus_in;
         lead_ff <= lead_in;
         pend_ff <= pend_in;
         sel_ff  <= sel_in;
      end
   end

   always_comb begin
      logic [7:0] b;
      logic       taken;
      logic       drop;
      logic       raw;
      logic [1:0] n;
      rsp_type    res [2];
      logic [1:0] pend;
      logic [7:0] lead;
      logic       sel;

      b      = req_data.in_byte;
      taken  = 1'b0;
      drop   = 1'b0;
      raw    = 1'b0;
      n      = '0;
      res[0] = '0;
      res[1] = '0;
      pend   = pend_ff;
      lead   = lead_ff;
      sel    = sel_ff;

      if (req_data.string_first) begin
         pend = '0;
         sel  = 1'b0;
         if (b == SELECTOR) begin
            sel   = 1'b1;
            taken = 1'b1;
         end
      end

      if (!taken && pend != 2'd0) begin
         if (b[7:6] == 2'b10) begin
            taken = 1'b1;
            pend  = pend - 2'd1;
            if (pend == 2'd0) begin
               res[n[0]] = '{(lead < LEAD3_MIN) ? fold_two(lead, b, rus_ff) : QMARK,
                             1'b1, 1'b0};
               n = n + 2'd1;
            end
         end else begin
            res[n[0]] = '{QMARK, 1'b1, 1'b0};
            n    = n + 2'd1;
            pend = '0;
         end
      end

      if (!taken) begin
         if (b <= ASCII_MAX) begin
            res[n[0]] = '{b, 1'b1, 1'b0};
            n = n + 2'd1;
            if (b == 8'h00) sel = 1'b0;
         end else if (in_rng(b, LEAD_MIN, LEAD_MAX)) begin
            lead = b;
            pend = (b < LEAD3_MIN) ? 2'd1 : ((b < LEAD4_MIN) ? 2'd2 : 2'd3);
            if (b >= LEAD4_MIN) sel = 1'b0;
         end else begin
            raw = rus_ff && (in_rng(b, RAW_LO, RAW_HI) || b == RAW_ONE);
            sel = 1'b0;
            res[n[0]] = '{raw ? b : QMARK, 1'b1, 1'b0};
            n = n + 2'd1;
         end
      end

      if (req_data.string_last) begin
         if (pend != 2'd0) begin
            drop = rus_ff && sel && pend == 2'd1 && (lead == LEAD_D0 || lead == LEAD_D1);
            if (!drop) begin
               res[n[0]] = '{QMARK, 1'b1, 1'b0};
               n = n + 2'd1;
            end
            pend = '0;
         end
         if (n == 2'd0) begin
            res[0] = '{8'h00, 1'b0, 1'b0};
            n = 2'd1;
         end
         if (n == 2'd2) res[1].string_end = 1'b1;
         else res[0].string_end = 1'b1;
         sel = 1'b0;
      end

      rus_in  = csr_wr_en ? csr_wr_data : rus_ff;
      lead_in = req_accept ? lead : lead_ff;
      pend_in = req_accept ? pend : pend_ff;
      sel_in  = req_accept ? sel : sel_ff;

      push.num   = req_accept ? n : 2'd0;
      push.slot0 = res[0];
      push.slot1 = res[1];
   end

endmodule

`default_nettype wire

[rtl/core/ufold_queue.sv]
// Result queue between front and back: up to two words written, one read per cycle.
// Uses ufold_pkg.
`default_nettype none

module ufold_queue
   import ufold_pkg::*;
#(
   parameter int DEPTH = 4
) (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire push_type push,
   input  wire logic     pop,
   output logic          room2,
   output logic          not_empty,
   output rsp_type       head
);

   localparam int PW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   rsp_type       mem [DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;

   always_ff @(posedge clock) begin
      if (push.num != 2'd0) mem[wr_ptr_ff] <= push.slot0;
      if (push.num == 2'd2) mem[PW'(wr_ptr_ff + 1'b1)] <= push.slot1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_comb begin
      wr_ptr_in = PW'(wr_ptr_ff + PW'(push.num));
      rd_ptr_in = pop ? PW'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      count_in  = CW'(count_ff + CW'(push.num) - CW'(pop));
   end

   assign room2     = (count_ff <= CW'(DEPTH - 2));
   assign not_empty = (count_ff != '0);
   assign head      = mem[rd_ptr_ff];

endmodule

`default_nettype wire

[rtl/core/ufold_back.sv]
// Back end: output register that pops the result queue and drives the rsp channel.
// Uses ufold_pkg.
`default_nettype none

module ufold_back
   import ufold_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    not_empty,
   input  wire rsp_type head,
   output logic         pop,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_data
);

   logic    valid_ff, valid_in;
   rsp_type data_ff, data_in;

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else valid_ff <= valid_in;
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   always_comb begin
      pop      = not_empty && (!valid_ff || !rsp_stall);
      valid_in = pop ? 1'b1 : (valid_ff && rsp_stall);
      data_in  = pop ? head : data_ff;
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

`default_nettype wire

[rtl/core/utf8_to_panel_char_folder.sv]
// Top level of the UTF-8 to panel character folder: front, result queue, back.
// Uses ufold_pkg, ufold_front, ufold_queue, ufold_back.
//
//   channel  ports                           width  direction
//   req      req_valid, req_stall, req_data  10     in
//   rsp      rsp_valid, rsp_stall, rsp_data  10     out
//   csr      csr_wr_en, csr_wr_data          1      in
//
// One input byte per cycle while req_stall is low; each byte gives zero, one or two words.
// After its byte is taken, a word passes the queue write, then the output register, to reach rsp.
// The output register drains one word per cycle when rsp_stall is low; a byte giving two
// words sends them in turn; req_stall rises while the queue has fewer than two free slots.
// Synchronous reset clears mode, sequence state, queue and output valid.
`default_nettype none

module utf8_to_panel_char_folder
   import ufold_pkg::*;
#(
   parameter int QUEUE_DEPTH = 4
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    csr_wr_en,
   input  wire logic    csr_wr_data,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_data
);

   push_type push;
   logic     room2;
   logic     not_empty;
   logic     pop;
   rsp_type  head;
   logic     req_accept;

   assign req_stall  = !room2;
   assign req_accept = req_valid && room2;

   ufold_front u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_accept  (req_accept),
      .req_data    (req_data),
      .push        (push)
   );

   ufold_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .pop       (pop),
      .room2     (room2),
      .not_empty (not_empty),
      .head      (head)
   );

   ufold_back u_back (
      .clock     (clock),
      .reset     (reset),
      .not_empty (not_empty),
      .head      (head),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

[tb/tb_top.sv]
// Self-checking testbench for utf8_to_panel_char_folder.
// Walks a directed table, then random strings over both modes; results are checked
// against table words or a local predictor. Depends on ufold_pkg and the block's RTL.
`timescale 1ns / 100ps

module tb_top;
   import ufold_pkg::*;

   localparam int WORD_TARGET  = 1100;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int SETTLE_WAIT  = 6;
   localparam int REPORT_LIMIT = 10;

   localparam logic [0:95][7:0] CYR_MAP = {
      8'h20, 8'hA2, 8'h3F, 8'h3F, 8'h3F, 8'h53, 8'h49, 8'h49,
      8'h4A, 8'h3F, 8'h3F, 8'h3F, 8'h3F, 8'h3F, 8'hCC, 8'h3F,
      8'h41, 8'hA0, 8'h42, 8'hA1, 8'hE0, 8'h45, 8'hA3, 8'hA4,
      8'hA5, 8'hA6, 8'h4B, 8'hA7, 8'h4D, 8'h48, 8'h4F, 8'hA8,
      8'h50, 8'h43, 8'h54, 8'hA9, 8'hAA, 8'h58, 8'hE1, 8'hAB,
      8'hAC, 8'hE2, 8'hAD, 8'hAE, 8'h62, 8'hAF, 8'hB0, 8'hB1,
      8'h61, 8'hB2, 8'hB3, 8'hB4, 8'hE3, 8'h65, 8'hB6, 8'hB7,
      8'hB8, 8'hB9, 8'hBA, 8'hBB, 8'hBC, 8'hBD, 8'h6F, 8'hBE,
      8'h70, 8'h63, 8'hBF, 8'h79, 8'hE4, 8'h78, 8'hE5, 8'hC0,
      8'hC1, 8'hE6, 8'hC2, 8'hC3, 8'hC4, 8'hC5, 8'hC6, 8'hC7,
      8'h4E, 8'hB5, 8'h3F, 8'h3F, 8'h3F, 8'h73, 8'h69, 8'h69,
      8'h6A, 8'h3F, 8'h3F, 8'h3F, 8'h3F, 8'h3F, 8'hCC, 8'h3F
   };

   typedef struct packed {
      req_type    w;
      logic       mode;
      logic       typed;
      logic [1:0] n;
      rsp_type    r0;
      rsp_type    r1;
   } plan_row_type;

   logic    clock       = 1'b0;
   logic    reset       = 1'b1;
   logic    csr_wr_en   = 1'b0;
   logic    csr_wr_data = 1'b0;
   logic    req_valid   = 1'b0;
   req_type req_data    = '0;
   logic    rsp_stall   = 1'b0;
   logic    req_stall;
   logic    rsp_valid;
   rsp_type rsp_data;

   rsp_type      expected_chars[$];
   rsp_type      fresh_chars[$];
   req_type      string_words[$];
   plan_row_type plan[$];

   logic       rus_mode  = 1'b0;
   logic [7:0] cur_lead  = '0;
   logic [1:0] cur_pend  = '0;
   logic       sel_open  = 1'b0;
   logic       steady    = 1'b0;
   int         fail_count   = 0;
   int         cycle_count  = 0;

   utf8_to_panel_char_folder u_top (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAIL utf8_to_panel_char_folder");
         $finish;
      end
   end

   function automatic logic span(input logic [7:0] c, input logic [7:0] lo,
                                 input logic [7:0] hi);
      return (c >= lo) && (c <= hi);
   endfunction

   // upper case when bit 0 equals up_par, else the lower case letter
   function automatic logic [7:0] letter_case(input logic [7:0] c, input logic up_par,
                                              input logic [7:0] up);
      return (c[0] == up_par) ? up : (up | 8'h20);
   endfunction

   function automatic logic [7:0] latin_letter(input logic [7:0] ld, input logic [7:0] c,
                                               input logic rus);
      logic [7:0] v;
      logic [7:0] r;
      r = QMARK;
      if (ld == LEAD_C3) begin
         if (span(c, 8'h80, 8'h85)) r = "A";
         else if (span(c, 8'h88, 8'h8B)) r = "E";
         else if (span(c, 8'h8C, 8'h8F)) r = "I";
         else if (span(c, 8'h92, 8'h96)) r = "O";
         else if (span(c, 8'h99, 8'h9C)) r = "U";
         else if (span(c, 8'hA0, 8'hA5)) r = "a";
         else if (span(c, 8'hA8, 8'hAB)) r = "e";
         else if (span(c, 8'hAC, 8'hAF)) r = "i";
         else if (span(c, 8'hB2, 8'hB6)) r = "o";
         else if (span(c, 8'hB9, 8'hBC)) r = "u";
      end else if (ld == LEAD_C4) begin
         if (span(c, 8'h80, 8'h85)) r = letter_case(c, 1'b0, "A");
         else if (span(c, 8'h86, 8'h8D)) r = letter_case(c, 1'b0, "C");
         else if (span(c, 8'h8E, 8'h91)) r = letter_case(c, 1'b0, "D");
         else if (span(c, 8'h92, 8'h9B)) r = letter_case(c, 1'b0, "E");
         else if (span(c, 8'h9C, 8'hA3)) r = letter_case(c, 1'b0, "G");
         else if (span(c, 8'hA4, 8'hA7)) r = letter_case(c, 1'b0, "H");
         else if (span(c, 8'hA8, 8'hB3)) r = letter_case(c, 1'b0, "I");
         else if (span(c, 8'hB4, 8'hB5)) r = letter_case(c, 1'b0, "J");
         else if (span(c, 8'hB6, 8'hB7)) r = letter_case(c, 1'b0, "K");
         else if (c == 8'hB8) r = "k";
         else if (span(c, 8'hB9, 8'hBF)) r = letter_case(c, 1'b1, "L");
      end else if (ld == LEAD_C5) begin
         if (span(c, 8'h80, 8'h82)) r = letter_case(c, 1'b1, "L");
         else if (span(c, 8'h83, 8'h88)) r = letter_case(c, 1'b1, "N");
         else if (c == 8'h89) r = "n";
         else if (span(c, 8'h8A, 8'h8B)) r = letter_case(c, 1'b0, "N");
         else if (span(c, 8'h8C, 8'h93)) r = letter_case(c, 1'b0, "O");
         else if (span(c, 8'h94, 8'h99)) r = letter_case(c, 1'b0, "R");
         else if (span(c, 8'h9A, 8'hA1)) r = letter_case(c, 1'b0, "S");
         else if (span(c, 8'hA2, 8'hA7)) r = letter_case(c, 1'b0, "T");
         else if (span(c, 8'hA8, 8'hB3)) r = letter_case(c, 1'b0, "U");
         else if (span(c, 8'hB4, 8'hB5)) r = letter_case(c, 1'b0, "W");
         else if (span(c, 8'hB6, 8'hB8)) r = letter_case(c, 1'b0, "Y");
         else if (span(c, 8'hB9, 8'hBE)) r = letter_case(c, 1'b1, "Z");
      end else if (rus && (ld == LEAD_D0 || ld == LEAD_D1)) begin
         v = c + ((ld == LEAD_D0) ? CYR_OFF_D0 : CYR_OFF_D1);
         if (v < ROM_BASE) r = v;
         else r = CYR_MAP[7'(v - ROM_BASE)];
      end
      return r;
   endfunction

   function automatic rsp_type mk_char(input logic [7:0] c, input logic v, input logic e);
      rsp_type r;
      r.panel_char = c;
      r.char_valid = v;
      r.string_end = e;
      return r;
   endfunction

   function automatic req_type mk_word(input logic [7:0] b, input logic f, input logic l);
      req_type w;
      w.in_byte      = b;
      w.string_first = f;
      w.string_last  = l;
      return w;
   endfunction

   // Advance the predictor by one input word; results land in fresh_chars.
   task automatic fold_word(input req_type w);
      logic [7:0] b;
      logic       done;
      logic       raw;
      logic       drop;
      rsp_type    tail;
      fresh_chars.delete();
      b = w.in_byte;
      done = 1'b0;
      if (w.string_first) begin
         cur_pend = '0;
         sel_open = 1'b0;
         if (b == SELECTOR) begin
            sel_open = 1'b1;
            done = 1'b1;
         end
      end
      if (!done && cur_pend != 0) begin
         if (span(b, 8'h80, 8'hBF)) begin
            done = 1'b1;
            cur_pend = cur_pend - 2'd1;
            if (cur_pend == 0)
               fresh_chars.push_back(mk_char((cur_lead < LEAD3_MIN) ?
                  latin_letter(cur_lead, b, rus_mode) : QMARK, 1'b1, 1'b0));
         end else begin
            fresh_chars.push_back(mk_char(QMARK, 1'b1, 1'b0));
            cur_pend = '0;
         end
      end
      if (!done) begin
         if (b <= ASCII_MAX) begin
            fresh_chars.push_back(mk_char(b, 1'b1, 1'b0));
            if (b == 8'h00) sel_open = 1'b0;
         end else if (span(b, LEAD_MIN, LEAD_MAX)) begin
            cur_lead = b;
            cur_pend = (b < LEAD3_MIN) ? 2'd1 : ((b < LEAD4_MIN) ? 2'd2 : 2'd3);
            if (b >= LEAD4_MIN) sel_open = 1'b0;
         end else begin
            raw = rus_mode && (span(b, RAW_LO, RAW_HI) || b == RAW_ONE);
            sel_open = 1'b0;
            fresh_chars.push_back(mk_char(raw ? b : QMARK, 1'b1, 1'b0));
         end
      end
      if (w.string_last) begin
         if (cur_pend != 0) begin
            drop = rus_mode && sel_open && cur_pend == 2'd1 &&
                   (cur_lead == LEAD_D0 || cur_lead == LEAD_D1);
            if (!drop) fresh_chars.push_back(mk_char(QMARK, 1'b1, 1'b0));
            cur_pend = '0;
         end
         if (fresh_chars.size() == 0) fresh_chars.push_back(mk_char(8'h00, 1'b0, 1'b0));
         tail = fresh_chars.pop_back();
         tail.string_end = 1'b1;
         fresh_chars.push_back(tail);
         sel_open = 1'b0;
      end
   endtask

   task automatic send_word(input req_type w);
      while (!steady && $urandom_range(0, 99) < 26) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= w;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      fold_word(w);
   endtask

   task automatic drain(input int extra);
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_chars.size() != 0) @(posedge clock);
      repeat (extra) @(posedge clock);
   endtask

   task automatic set_mode(input logic m);
      drain(SETTLE_WAIT);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= m;
      @(posedge clock);
      rus_mode = m;
      csr_wr_en <= 1'b0;
   endtask

   task automatic add_row(input logic [7:0] b, input logic f, input logic l, input logic m,
                          input logic typed, input logic [1:0] n, input rsp_type r0,
                          input rsp_type r1);
      plan_row_type row;
      row.w     = mk_word(b, f, l);
      row.mode  = m;
      row.typed = typed;
      row.n     = n;
      row.r0    = r0;
      row.r1    = r1;
      plan.push_back(row);
   endtask

   function automatic logic [7:0] cont_byte();
      return 8'($urandom_range(8'h80, 8'hBF));
   endfunction

   // Build one string of random characters into string_words, marks included.
   task automatic make_string();
      int nchar;
      int kind;
      int k;
      int cut;
      logic [7:0] ld;
      req_type w;
      string_words.delete();
      if ($urandom_range(0, 99) < 40) string_words.push_back(mk_word(SELECTOR, 1'b0, 1'b0));
      nchar = $urandom_range(1, 8);
      for (int i = 0; i < nchar; i++) begin
         kind = $urandom_range(0, 99);
         if (kind < 20) begin
            string_words.push_back(mk_word(($urandom_range(0, 9) == 0) ? 8'h00 :
                                   8'($urandom_range(0, 8'h7F)), 1'b0, 1'b0));
         end else if (kind < 40) begin
            ld = 8'($urandom_range(LEAD_C3, LEAD_C5));
            string_words.push_back(mk_word(ld, 1'b0, 1'b0));
            string_words.push_back(mk_word(cont_byte(), 1'b0, 1'b0));
         end else if (kind < 58) begin
            ld = ($urandom_range(0, 1) == 0) ? LEAD_D0 : LEAD_D1;
            string_words.push_back(mk_word(ld, 1'b0, 1'b0));
            string_words.push_back(mk_word(cont_byte(), 1'b0, 1'b0));
         end else if (kind < 64) begin
            string_words.push_back(mk_word(8'($urandom_range(LEAD_MIN, 8'hDF)), 1'b0, 1'b0));
            string_words.push_back(mk_word(cont_byte(), 1'b0, 1'b0));
         end else if (kind < 75) begin
            ld = (kind < 70) ? 8'($urandom_range(LEAD3_MIN, 8'hEF)) :
                               8'($urandom_range(LEAD4_MIN, LEAD_MAX));
            k = (ld < LEAD4_MIN) ? 2 : 3;
            string_words.push_back(mk_word(ld, 1'b0, 1'b0));
            repeat (k) string_words.push_back(mk_word(cont_byte(), 1'b0, 1'b0));
         end else if (kind < 82) begin
            string_words.push_back(mk_word(($urandom_range(0, 1) == 0) ?
               8'($urandom_range(8'h80, 8'hC1)) : 8'($urandom_range(8'hF8, 8'hFF)),
               1'b0, 1'b0));
         end else if (kind < 90) begin
            ld = 8'($urandom_range(LEAD_MIN, LEAD_MAX));
            k = (ld < LEAD3_MIN) ? 1 : ((ld < LEAD4_MIN) ? 2 : 3);
            cut = $urandom_range(0, k - 1);
            string_words.push_back(mk_word(ld, 1'b0, 1'b0));
            repeat (cut) string_words.push_back(mk_word(cont_byte(), 1'b0, 1'b0));
         end else begin
            string_words.push_back(mk_word(8'($urandom_range(0, 255)), 1'b0, 1'b0));
         end
      end
      if ($urandom_range(0, 99) < 25)
         string_words.push_back(mk_word(($urandom_range(0, 1) == 0) ? LEAD_D0 : LEAD_D1,
                                        1'b0, 1'b0));
      for (int i = 0; i < string_words.size(); i++) begin
         w = string_words[i];
         w.string_first = (i == 0) ? ($urandom_range(0, 99) >= 5) :
                                     ($urandom_range(0, 99) < 3);
         w.string_last  = (i == string_words.size() - 1) ? ($urandom_range(0, 99) >= 5) :
                                                           ($urandom_range(0, 99) < 3);
         string_words[i] = w;
      end
   endtask

   always @(posedge clock) begin
      rsp_stall <= steady ? 1'b0 : ($urandom_range(0, 99) < 26);
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_chars.size() == 0) begin
            fail_count <= fail_count + 1;
            if (fail_count < REPORT_LIMIT)
               $display("unexpected word: got %h/%b/%b", rsp_data.panel_char,
                        rsp_data.char_valid, rsp_data.string_end);
         end else if (expected_chars[0] !== rsp_data) begin
            fail_count <= fail_count + 1;
            if (fail_count < REPORT_LIMIT)
               $display("mismatch: expected %h/%b/%b got %h/%b/%b",
                        expected_chars[0].panel_char, expected_chars[0].char_valid,
                        expected_chars[0].string_end, rsp_data.panel_char,
                        rsp_data.char_valid, rsp_data.string_end);
            void'(expected_chars.pop_front());
         end else begin
            void'(expected_chars.pop_front());
         end
      end
   end

   initial begin
      plan_row_type row;
      rsp_type      none;
      int           phase_words;
      logic         held;
      logic         phase_modes [8];
      none = '0;
      held = 1'b0;
      phase_modes = '{1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0};

      add_row(8'h00, 1'b1, 1'b0, 1'b0, 1'b1, 2'd1, mk_char(8'h00, 1'b1, 1'b0), none);
      add_row(8'h7F, 1'b0, 1'b0, 1'b0, 1'b1, 2'd1, mk_char(8'h7F, 1'b1, 1'b0), none);
      add_row(8'h15, 1'b0, 1'b0, 1'b0, 1'b1, 2'd1, mk_char(8'h15, 1'b1, 1'b0), none);
      add_row(8'hFF, 1'b0, 1'b1, 1'b0, 1'b1, 2'd1, mk_char(QMARK, 1'b1, 1'b1), none);
      add_row(8'h15, 1'b1, 1'b0, 1'b0, 1'b0, 2'd0, none, none);
      add_row(8'hC3, 1'b0, 1'b0, 1'b0, 1'b0, 2'd0, none, none);
      add_row(8'h80, 1'b0, 1'b0, 1'b0, 1'b1, 2'd1, mk_char("A", 1'b1, 1'b0), none);
      add_row(8'hC5, 1'b0, 1'b0, 1'b0, 1'b0, 2'd0, none, none);
      add_row(8'hA2, 1'b0, 1'b0, 1'b0, 1'b1, 2'd1, mk_char("T", 1'b1, 1'b0), none);
      add_row(8'hC4, 1'b0, 1'b0, 1'b0, 1'b0, 2'd0, none, none);
      add_row(8'hBF, 1'b0, 1'b0, 1'b0, 1'b0, 2'd0, none, none);
      add_row(8'hF7, 1'b0, 1'b0, 1'b0, 1'b0, 2'd0, none, none);
      add_row(8'h80, 1'b0, 1'b0, 1'b0, 1'b0, 2'd0, none, none);
      add_row(8'hBF, 1'b0, 1'b0, 1'b0, 1'b0, 2'd0, none, none);
      add_row(8'hAC, 1'b0, 1'b0, 1'b0, 1'b0, 2'd0, none, none);
      add_row(8'hC3, 1'b0, 1'b0, 1'b0, 1'b0, 2'd0, none, none);
      add_row(8'h41, 1'b0, 1'b1, 1'b0, 1'b1, 2'd2, mk_char(QMARK, 1'b1, 1'b0),
              mk_char("A", 1'b1, 1'b1));
      add_row(8'hC3, 1'b1, 1'b1, 1'b0, 1'b1, 2'd1, mk_char(QMARK, 1'b1, 1'b1), none);
      add_row(8'h15, 1'b1, 1'b0, 1'b1, 1'b0, 2'd0, none, none);
      add_row(8'hD0, 1'b0, 1'b0, 1'b1, 1'b0, 2'd0, none, none);
      add_row(8'h90, 1'b0, 1'b0, 1'b1, 1'b0, 2'd0, none, none);
      add_row(8'hD1, 1'b0, 1'b0, 1'b1, 1'b0, 2'd0, none, none);
      add_row(8'h8F, 1'b0, 1'b0, 1'b1, 1'b0, 2'd0, none, none);
      add_row(8'hD1, 1'b0, 1'b1, 1'b1, 1'b1, 2'd1, mk_char(8'h00, 1'b0, 1'b1), none);
      add_row(8'h8B, 1'b1, 1'b0, 1'b1, 1'b1, 2'd1, mk_char(8'h8B, 1'b1, 1'b0), none);
      add_row(8'h95, 1'b0, 1'b1, 1'b1, 1'b1, 2'd1, mk_char(8'h95, 1'b1, 1'b1), none);
      add_row(8'h15, 1'b1, 1'b1, 1'b1, 1'b1, 2'd1, mk_char(8'h00, 1'b0, 1'b1), none);

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      set_mode(1'b0);

      foreach (plan[i]) begin
         row = plan[i];
         if (row.mode != rus_mode) set_mode(row.mode);
         send_word(row.w);
         if (row.typed) begin
            if (row.n > 0) expected_chars.push_back(row.r0);
            if (row.n > 1) expected_chars.push_back(row.r1);
         end else begin
            foreach (fresh_chars[j]) expected_chars.push_back(fresh_chars[j]);
         end
      end

      for (int p = 0; p < 8; p++) begin
         set_mode(phase_modes[p]);
         steady = (p == 3);
         phase_words = 0;
         while (phase_words < WORD_TARGET / 8) begin
            make_string();
            foreach (string_words[i]) begin
               send_word(string_words[i]);
               foreach (fresh_chars[j]) expected_chars.push_back(fresh_chars[j]);
               phase_words++;
            end
            // hold the sender once mid-phase until all words are back
            if (p == 5 && !held && phase_words > WORD_TARGET / 16) begin
               drain(0);
               held = 1'b1;
            end
         end
         steady = 1'b0;
      end

      drain(3 * SETTLE_WAIT);
      if (fail_count == 0 && expected_chars.size() == 0) begin
         $display("PASS utf8_to_panel_char_folder");
      end else begin
         $display("FAIL utf8_to_panel_char_folder");
      end
      $finish;
   end

endmodule
